// ----- design/psfp_pkg.sv -----
// Shared constants, types and codes of the particle sensor frame parser.
`default_nettype none
package psfp_pkg;

  localparam int WORD_COUNT = 15;
  localparam int FRAME_LEN  = 2 + 2 * WORD_COUNT;
  localparam int SUM_LEN    = 2 * WORD_COUNT;
  localparam int POS_W      = $clog2(FRAME_LEN + 1);
  localparam int IDX_W      = $clog2(WORD_COUNT);
  localparam int MEM_DEPTH  = WORD_COUNT - 1;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int WI_W       = 4;

  localparam logic [7:0] START_BYTE = 8'h42;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_START = 2'd1,
    ST_MISMATCH = 2'd2
  } frame_status_e;

  typedef struct packed {
    logic             byte_en;
    logic             rd_en;
    logic             out_load;
    logic             last;
    logic [IDX_W-1:0] idx;
  } psfp_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_free;
  } psfp_sts_t;

endpackage
`default_nettype wire

// ----- design/psfp_dp.sv -----
// Datapath: byte position, running sum, word assembly, word store and output register.
`default_nettype none
module psfp_dp
  import psfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire psfp_cmd_t   cmd_i,
  output psfp_sts_t        sts_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic        m_tready_i,
  output logic             m_tvalid_o,
  output logic [23:0]      m_tdata_o,
  output logic             m_tlast_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic             ok_q, ok_d;
  logic [7:0]       pend_q, pend_d;
  logic [15:0]      chk_q;
  frame_status_e    status_q;
  logic [15:0]      rdata_q;
  logic [15:0]      mem [MEM_DEPTH];

  logic             valid_q;
  logic [23:0]      data_q;
  logic             last_q;

  localparam logic [POS_W-1:0] LastPos = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] SumEnd  = POS_W'(SUM_LEN);
  localparam logic [POS_W-1:0] EndPos  = POS_W'(FRAME_LEN);

  logic             active;
  logic             wr_en;
  logic [POS_W-1:0] wofs;
  logic [15:0]      word;
  logic [15:0]      out_val;

  assign active = cmd_i.byte_en && !frame_start_i && (pos_q < EndPos);
  assign wofs   = (pos_q - POS_W'(3)) >> 1;
  assign word   = {pend_q, rx_byte_i};
  assign wr_en  = active && pos_q[0] && (pos_q >= POS_W'(3)) && (pos_q != LastPos);

  assign sts_o.frame_end = !frame_start_i && (pos_q == LastPos);
  assign sts_o.out_free  = !valid_q || m_tready_i;

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    ok_d   = ok_q;
    pend_d = pend_q;
    if (cmd_i.byte_en && frame_start_i) begin
      ok_d   = (rx_byte_i == START_BYTE);
      sum_d  = {8'd0, rx_byte_i};
      pend_d = 8'd0;
      pos_d  = POS_W'(1);
    end else if (active) begin
      pos_d = pos_q + POS_W'(1);
      if (pos_q < SumEnd) sum_d = sum_q + {8'd0, rx_byte_i};
      if (!pos_q[0] && (pos_q >= POS_W'(2))) pend_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= EndPos;
      sum_q  <= '0;
      ok_q   <= 1'b0;
      pend_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      ok_q   <= ok_d;
      pend_q <= pend_d;
    end
  end

  // checksum word and frame status, captured on the final byte
  always_ff @(posedge clk_i) begin
    if (active && (pos_q == LastPos)) begin
      chk_q <= word;
      if (!ok_q) status_q <= ST_BAD_START;
      else if (sum_q != word) status_q <= ST_MISMATCH;
      else status_q <= ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[ADDR_W'(wofs)] <= word;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem[ADDR_W'(cmd_i.idx)];
  end

  always_comb begin
    out_val = cmd_i.last ? chk_q : rdata_q;
    if (status_q == ST_BAD_START) out_val = 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      data_q <= {2'b00, status_q, out_val, WI_W'(cmd_i.idx)};
      last_q <= cmd_i.last;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

endmodule
`default_nettype wire

// ----- design/psfp_ctrl.sv -----
// Controller: byte intake and word-by-word emission sequencing.
`default_nettype none
module psfp_ctrl
  import psfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  input  wire psfp_sts_t sts_i,
  output psfp_cmd_t      cmd_o
);

  localparam logic [1:0] S_RECV = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(WORD_COUNT - 1);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;

  assign s_tready_o = (state_q == S_RECV);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    cmd_o.byte_en  = accept;
    cmd_o.rd_en    = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.last     = (idx_q == LastIdx);
    cmd_o.idx      = idx_q;
    unique case (state_q)
      S_RECV: begin
        if (accept && sts_i.frame_end) begin
          state_d = S_RD;
          idx_d   = '0;
        end
      end
      S_RD: begin
        cmd_o.rd_en = (idx_q != LastIdx);
        state_d     = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (idx_q == LastIdx) begin
            state_d = S_RECV;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_RECV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RECV;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output loaded while occupied");

  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.frame_end) |=> (!s_tready_o && idx_q == '0))
    else $error("emission did not start at word zero");

  a_last_resumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.last) |=> s_tready_o)
    else $error("intake not resumed after last word");

  a_read_before_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q) == S_RD || $past(state_q) == S_WR)
    else $error("load without preceding read");

endmodule
`default_nettype wire

// ----- design/particle_sensor_frame_parser.sv -----
// Top level of the particle sensor frame parser.
// Input stream: one sensor byte per item in s_axis_tdata_i[7:0]; s_axis_tuser_i
// high marks byte 0 of a frame and restarts parsing, dropping any partial frame.
// Bytes outside a frame are accepted and ignored.
// Output stream: on the final byte of a frame, WORD_COUNT items (15) are sent,
// one per decoded big-endian word, word_index 0 first; tlast marks the checksum
// word. Every item carries the frame status (ok, bad start byte with zeroed
// words, checksum mismatch).
// Rate: a byte is taken every cycle while receiving. After the final byte the
// intake is held off while the word store is read back, word by word: a store
// read (S_RD), then an output register load (S_WR). A stalled receiver holds
// each word in S_WR, since each word waits for the output register.
// Intake resumes as soon as the last word sits in the output register.
// Reset: idle, waiting for a frame start, output empty.
`default_nettype none
module particle_sensor_frame_parser
  import psfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [3:0] word_index, [19:4] word_value,
                                             // [21:20] frame_status, [23:22] zero
  output logic             m_axis_tlast_o    // last_word
);

  psfp_cmd_t cmd;
  psfp_sts_t sts;

  psfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psfp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tlast_o     (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ----- dv/particle_sensor_frame_parser_tb.sv -----
// Testbench for the particle sensor frame parser: random byte streams, word predictor, checks.
`timescale 1ns / 100ps
module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEM_TARGET = 350;

  typedef struct {
    logic [3:0]    idx;
    logic [15:0]   value;
    frame_status_e status;
    logic          last;
  } word_item_t;

  class frame_scoreboard;
    int            byte_pos;
    logic [15:0]   sum;
    logic          start_ok;
    logic [7:0]    hi_byte;
    logic [15:0]   words [MEM_DEPTH];
    word_item_t    expected_words [$];
    int            errors;

    function new();
      byte_pos = FRAME_LEN;
      sum      = '0;
      start_ok = 1'b0;
      hi_byte  = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Returns 0 when the byte is ignored.
    function bit note_byte(logic [7:0] b, logic start);
      int            p;
      int            idx;
      logic [15:0]   w;
      frame_status_e status;
      word_item_t    item;
      if (start) begin
        start_ok = (b == START_BYTE);
        sum      = {8'h00, b};
        hi_byte  = '0;
        byte_pos = 1;
        return 1'b1;
      end
      if (byte_pos >= FRAME_LEN) return 1'b0;
      p = byte_pos;
      byte_pos = p + 1;
      if (p < SUM_LEN) sum = sum + b;
      if (p < 2) return 1'b1;
      if ((p % 2) == 0) begin
        hi_byte = b;
        return 1'b1;
      end
      idx = (p - 3) / 2;
      w   = {hi_byte, b};
      if (idx < WORD_COUNT - 1) begin
        words[idx] = w;
        return 1'b1;
      end
      if (!start_ok) status = ST_BAD_START;
      else if (sum != w) status = ST_MISMATCH;
      else status = ST_OK;
      for (int i = 0; i < WORD_COUNT; i++) begin
        item.idx    = i[3:0];
        item.value  = start_ok ? ((i < WORD_COUNT - 1) ? words[i] : w) : 16'h0000;
        item.status = status;
        item.last   = (i == WORD_COUNT - 1);
        expected_words.push_back(item);
      end
      return 1'b1;
    endfunction

    function void check_word(logic [23:0] data, logic last);
      word_item_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected word: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (data[3:0] !== e.idx) begin
        $error("word_index: expected %0d, got %0d", e.idx, data[3:0]);
        errors++;
      end
      if (data[19:4] !== e.value) begin
        $error("word_value: expected %h, got %h", e.value, data[19:4]);
        errors++;
      end
      if (data[21:20] !== e.status) begin
        $error("frame_status: expected %0d, got %0d", e.status, data[21:20]);
        errors++;
      end
      if (data[23:22] !== 2'b00) begin
        $error("tdata padding: expected 0, got %b", data[23:22]);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_word: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  frame_scoreboard sb = new();
  int fed_items;
  int idle_cycles;
  int send_calm;
  int recv_calm;

  particle_sensor_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Random idle gap before an item, with occasional runs of back-to-back items.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (sb.note_byte(b, start)) fed_items++;
  endtask

  // fill: 0 random payload, 1 all zeros, 2 all ones.
  task automatic send_frame(input logic [7:0] head, input bit corrupt_sum, input int fill);
    logic [7:0]  frame [FRAME_LEN];
    logic [15:0] csum;
    frame[0] = head;
    for (int i = 1; i < SUM_LEN; i++) begin
      case (fill)
        1: frame[i] = 8'h00;
        2: frame[i] = 8'hFF;
        default: frame[i] = 8'($urandom);
      endcase
    end
    csum = '0;
    for (int i = 0; i < SUM_LEN; i++) csum = csum + frame[i];
    if (corrupt_sum) csum = csum ^ 16'($urandom_range(1, 65535));
    frame[FRAME_LEN-2] = csum[15:8];
    frame[FRAME_LEN-1] = csum[7:0];
    for (int i = 0; i < FRAME_LEN; i++) send_byte(frame[i], i == 0);
  endtask

  task automatic send_partial(input int count);
    send_byte(START_BYTE, 1'b1);
    for (int i = 0; i < count; i++) send_byte(8'($urandom), 1'b0);
  endtask

  function automatic logic [7:0] wrong_head();
    logic [7:0] h;
    do h = 8'($urandom); while (h == START_BYTE);
    return h;
  endfunction

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      int stall;
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_word(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** particle_sensor_frame_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    int kind;
    int fill;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    fed_items     = 0;
    idle_cycles   = 0;
    send_calm     = 0;
    recv_calm     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle bytes after reset
    send_byte(START_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    // good frames, extreme payloads
    send_frame(START_BYTE, 1'b0, 0);
    send_frame(START_BYTE, 1'b0, 1);
    send_frame(START_BYTE, 1'b0, 2);
    // bad start byte, checksum mismatch
    send_frame(8'h00, 1'b0, 0);
    send_frame(8'hFF, 1'b1, 2);
    send_frame(START_BYTE, 1'b1, 0);
    // restart mid-frame, and restart on the final byte
    send_partial(5);
    send_partial(FRAME_LEN - 2);
    send_frame(START_BYTE, 1'b0, 0);
    // bytes past the end of a frame
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);

    while (fed_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
      if (kind < 60) begin
        send_frame(START_BYTE, 1'b0, fill);
      end else if (kind < 72) begin
        send_frame(START_BYTE, 1'b1, fill);
      end else if (kind < 82) begin
        send_frame(wrong_head(), 1'($urandom_range(0, 1)), fill);
      end else if (kind < 92) begin
        send_partial($urandom_range(0, FRAME_LEN - 2));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** particle_sensor_frame_parser: PASSED **");
    end else begin
      $display("** particle_sensor_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
